>>> rtl/rkpd_pkg.sv
// Shared types and field widths for the random-key permutation decoder.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package rkpd_pkg;

   localparam int KEY_W = 32;
   localparam int ID_W  = 16;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic insert;
      logic drain;
   } cmd_type;

   typedef struct packed {
      logic last_one;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/rkpd_controller.sv
// Sequencer of the decoder: load phase, fill count and drain phase.
// Depends on rkpd_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none
module rkpd_controller #(
   parameter int MAX_ITEMS = 64
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  wire                   last_in,
   input  rkpd_pkg::status_type  status,
   output logic                  busy,
   output rkpd_pkg::cmd_type     cmd
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   rkpd_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rkpd_pkg::ST_LOAD;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cmd.insert = 1'b0;
      cmd.drain  = 1'b0;
      busy       = 1'b0;
      case (state_ff)
         rkpd_pkg::ST_LOAD: begin
            if (start) begin
               cmd.insert = 1'b1;
               if (last_in || (count_ff == CNT_W'(MAX_ITEMS - 1))) begin
                  count_in = '0;
                  state_in = rkpd_pkg::ST_DRAIN;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         rkpd_pkg::ST_DRAIN: begin
            busy      = 1'b1;
            cmd.drain = 1'b1;
            if (status.last_one) begin
               state_in = rkpd_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = rkpd_pkg::ST_LOAD;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/rkpd_datapath.sv
// Insertion-sort cell chain and result register of the decoder.
// Depends on rkpd_pkg for widths and the command and status types.
`timescale 1ns / 1ps
`default_nettype none
module rkpd_datapath #(
   parameter int MAX_ITEMS = 64
) (
   input  wire                        clock,
   input  wire                        reset,
   input  rkpd_pkg::cmd_type          cmd,
   input  wire [rkpd_pkg::KEY_W-1:0]  in_key,
   input  wire [rkpd_pkg::ID_W-1:0]   in_id,
   output rkpd_pkg::status_type       status,
   output logic                       out_valid,
   output logic [rkpd_pkg::ID_W-1:0]  out_id,
   output logic [rkpd_pkg::KEY_W-1:0] out_key,
   output logic                       out_last
);

   logic [rkpd_pkg::KEY_W-1:0] key_ff [MAX_ITEMS];
   logic [rkpd_pkg::KEY_W-1:0] key_in [MAX_ITEMS];
   logic [rkpd_pkg::ID_W-1:0]  id_ff  [MAX_ITEMS];
   logic [rkpd_pkg::ID_W-1:0]  id_in  [MAX_ITEMS];
   logic [MAX_ITEMS-1:0]       valid_ff, valid_in, gt;

   logic                       out_valid_ff;
   logic [rkpd_pkg::ID_W-1:0]  out_id_ff;
   logic [rkpd_pkg::KEY_W-1:0] out_key_ff;
   logic                       out_last_ff;

   always_comb begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         gt[i]     = valid_ff[i] && (key_ff[i] > in_key);
         key_in[i] = key_ff[i];
         id_in[i]  = id_ff[i];
      end
      valid_in = valid_ff;
      if (cmd.insert) begin
         if (gt[0] || !valid_ff[0]) begin
            key_in[0] = in_key;
            id_in[0]  = in_id;
         end
         valid_in[0] = 1'b1;
         for (int i = 1; i < MAX_ITEMS; i++) begin
            if (gt[i-1]) begin
               key_in[i] = key_ff[i-1];
               id_in[i]  = id_ff[i-1];
            end else if (valid_ff[i-1] && (gt[i] || !valid_ff[i])) begin
               key_in[i] = in_key;
               id_in[i]  = in_id;
            end
            valid_in[i] = valid_ff[i] || valid_ff[i-1];
         end
      end else if (cmd.drain) begin
         for (int i = 0; i < MAX_ITEMS - 1; i++) begin
            key_in[i] = key_ff[i+1];
            id_in[i]  = id_ff[i+1];
         end
         valid_in = {1'b0, valid_ff[MAX_ITEMS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= cmd.drain;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         key_ff[i] <= key_in[i];
         id_ff[i]  <= id_in[i];
      end
      if (cmd.drain) begin
         out_id_ff   <= id_ff[0];
         out_key_ff  <= key_ff[0];
         out_last_ff <= !valid_ff[1];
      end
   end

   assign status.last_one = !valid_ff[1];
   assign out_valid       = out_valid_ff;
   assign out_id          = out_id_ff;
   assign out_key         = out_key_ff;
   assign out_last        = out_last_ff;

endmodule
`default_nettype wire

>>> rtl/random_key_permutation_decode_unit.sv
// Random-key permutation decoder: sorts up to MAX_ITEMS key/id beats, emits ids in key order.
// Each beat is written into the cell chain; after the last one, the first result passes
// from the chain head through the result register. Throughput: one beat per cycle while
// loading; N results drain one per cycle with busy high. The receiver cannot stall.
// Reset (synchronous, active high) empties the chain and returns to the load phase.
// Depends on rkpd_pkg, rkpd_controller and rkpd_datapath.
`timescale 1ns / 1ps
`default_nettype none
module random_key_permutation_decode_unit #(
   parameter int MAX_ITEMS = 64
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire [rkpd_pkg::KEY_W-1:0]  req_gene_key,
   input  wire [rkpd_pkg::ID_W-1:0]   req_item_id,
   input  wire                        req_last_in,
   output logic                       rsp_valid,
   output logic [rkpd_pkg::ID_W-1:0]  rsp_sorted_item,
   output logic [rkpd_pkg::KEY_W-1:0] rsp_sorted_key,
   output logic                       rsp_last_out
);

   rkpd_pkg::cmd_type    cmd;
   rkpd_pkg::status_type status;

   rkpd_controller #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .last_in (req_last_in),
      .status  (status),
      .busy    (busy),
      .cmd     (cmd)
   );

   rkpd_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .in_key    (req_gene_key),
      .in_id     (req_item_id),
      .status    (status),
      .out_valid (rsp_valid),
      .out_id    (rsp_sorted_item),
      .out_key   (rsp_sorted_key),
      .out_last  (rsp_last_out)
   );

endmodule
`default_nettype wire
